// ----- src/ctre_pkg.sv -----
// Shared types and constants of the charge time remaining estimator.
// Holds the payload structs, controller states, command and status groups.
// No dependencies.
package ctre_pkg;

   localparam int SOC_STEPS_DEFAULT = 100;

   // Width of the signed product and accumulator (33 x 25 bit products).
   localparam int ACC_W = 58;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_EMF_ENABLE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING_WEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING_BASE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERSTATE_ENABLE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERSTATE_WEIGHT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERSTATE_BASE   = 3'd5;

   localparam logic [15:0] WEIGHT_RESET = 16'd10000;
   localparam logic [15:0] BASE_RESET   = 16'd10000;
   localparam logic [7:0]  OBASE_RESET  = 8'd100;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_LOAD   = 2'd1,
      ACT_FINISH = 2'd2,
      ACT_REPORT = 2'd3
   } action_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [6:0]  soc_index;
      logic [15:0] profile_seconds;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic signed [31:0] remaining_seconds;
      logic               invalid;
   } rsp_type;

   typedef enum logic [2:0] {
      MUL_MEAS_BASE,
      MUL_W_T,
      MUL_BW_MF,
      MUL_REM_F,
      MUL_VAL_NUM
   } mul_sel_type;

   typedef enum logic [1:0] {
      DIV_STEP,
      DIV_BASE,
      DIV_OBASE
   } div_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FIN_INIT,
      ST_FIN_RD,
      ST_FIN_WR,
      ST_RPT_CHECK,
      ST_TR_RD,
      ST_TR_MUL,
      ST_TR_ACC,
      ST_TR_DST,
      ST_TR_DWT,
      ST_FC_MUL1,
      ST_FC_MUL2,
      ST_FC_ADD,
      ST_FC_DST,
      ST_FC_DWT,
      ST_CA_RD,
      ST_CA_MUL,
      ST_CA_ACC,
      ST_CA_DST,
      ST_CA_DWT,
      ST_OUT_RD,
      ST_OUT_MUL,
      ST_OUT_ACC,
      ST_OUT_DST,
      ST_OUT_DWT
   } state_type;

   typedef struct packed {
      logic        load_in;
      logic        do_clear;
      logic        write_step;
      logic        fin_init;
      logic        fin_rd;
      logic        fin_wr;
      logic        rpt_update;
      logic        set_factor_base;
      logic        trend_rd;
      logic        t_base;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        acc_ld;
      logic        acc_add;
      logic        div_start;
      div_sel_type div_sel;
      logic        t_ld;
      logic        factor_ld;
      logic        cache_wr;
      logic        rem_rd;
      logic        rsp_ok;
      logic        rsp_bad;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       bad_rpt;
      logic       same_soc;
      logic       cached_hit;
      logic       need_trend;
      logic       step_zero;
      logic       fin_last;
      logic       div_done;
   } status_type;

endpackage

// ----- src/ctre_div.sv -----
// Iterative signed divider: one quotient bit a cycle, saturated to 32 bits.
// Depends on ctre_pkg for the dividend width.
module ctre_div import ctre_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [ACC_W-1:0] dividend,
   input  logic [15:0]             divisor,
   output logic                    done,
   output logic signed [31:0]      quotient
);

   localparam int MAG_W = ACC_W - 1;
   localparam int CNT_W = $clog2(MAG_W + 1);

   logic             run_ff, run_in;
   logic             fin_ff, fin_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [MAG_W-1:0] num_ff, num_in;
   logic [15:0]      rem_ff, rem_in;
   logic [15:0]      den_ff, den_in;
   logic             neg_ff, neg_in;

   logic [ACC_W-1:0] mag_full;
   logic [16:0]      trial;
   logic             fits;

   // Magnitude of the dividend and one restoring step.
   always_comb begin
      mag_full = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
      trial    = {rem_ff, num_ff[MAG_W-1]};
      fits     = trial >= {1'b0, den_ff};
   end

   always_comb begin
      run_in = run_ff;
      fin_in = 1'b0;
      cnt_in = cnt_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(MAG_W);
         num_in = mag_full[MAG_W-1:0];
         rem_in = '0;
         den_in = divisor;
         neg_in = dividend[ACC_W-1];
      end else if (run_ff) begin
         rem_in = fits ? 16'(trial - {1'b0, den_ff}) : trial[15:0];
         num_in = {num_ff[MAG_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         fin_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         fin_ff <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // Sign and saturation of the finished quotient.
   always_comb begin
      if (neg_ff) begin
         if (num_ff > MAG_W'(33'h0_8000_0000)) begin
            quotient = 32'sh8000_0000;
         end else begin
            quotient = 32'(-num_ff[31:0]);
         end
      end else begin
         if (num_ff > MAG_W'(32'h7FFF_FFFF)) begin
            quotient = 32'sh7FFF_FFFF;
         end else begin
            quotient = num_ff[31:0];
         end
      end
   end

   assign done = fin_ff;

   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      run_ff |-> !start) else $error("divider restarted while running");
   a_done_once : assert property (@(posedge clock) disable iff (reset)
      fin_ff |=> !fin_ff) else $error("divider done held for two cycles");
   a_done_after_run : assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> $past(run_ff)) else $error("divider done without a run");

endmodule

// ----- src/ctre_dp.sv -----
// Datapath of the estimator: profile stores, runtime state, multiplier and
// the shared divider. Depends on ctre_pkg and ctre_div.
module ctre_dp import ctre_pkg::*; #(
   parameter int STEPS = SOC_STEPS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_data,
   input  cmd_type               cmd,
   output status_type            status,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SW = $clog2(STEPS);
   localparam int RW = $clog2(STEPS + 1);

   // Configuration registers.
   logic        emf_ff, oen_ff;
   logic [15:0] weight_ff, base_ff;
   logic [7:0]  ow_ff, obase_ff;

   // Stores.
   logic [15:0] step_mem  [STEPS];
   logic [23:0] rem_mem   [STEPS+1];
   logic [31:0] meas_mem  [STEPS];
   logic [31:0] cache_mem [STEPS+1];

   logic [STEPS-1:0] step_vld_ff, meas_vld_ff;
   logic [STEPS:0]   cache_vld_ff;

   logic [15:0] step_rd_ff;
   logic [31:0] meas_rd_ff;
   logic [23:0] rem_rd_ff;
   logic [31:0] cache_rd_ff;

   // Runtime state.
   req_type            in_ff;
   logic               pvalid_ff, started_ff, cur_ok_ff;
   logic [6:0]         cur_soc_ff, begin_ff;
   logic [31:0]        start_time_ff;
   logic signed [31:0] mf_ff, t_ff, factor_ff;
   logic [23:0]        run_ff;
   logic [SW-1:0]      fin_idx_ff;
   logic signed [ACC_W-1:0] prod_ff, acc_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   // Derived values.
   logic [7:0]         soc8, socm1_8, begin_eff;
   logic [RW-1:0]      soc_r;
   logic [SW-1:0]      socm1;
   logic [15:0]        base_eff, step_val, fin_step_val, divisor;
   logic [7:0]         obase_eff;
   logic [8:0]         num9;
   logic [31:0]        meas_eff;
   logic [23:0]        fin_sum;
   logic signed [31:0] out_val, div_q;
   logic signed [16:0] bw;
   logic signed [32:0] mul_a;
   logic signed [24:0] mul_b;
   logic               div_done, step_ok, meas_upd;

   always_comb begin
      soc8         = {1'b0, in_ff.soc_index};
      socm1_8      = soc8 - 8'd1;
      soc_r        = soc8[RW-1:0];
      socm1        = socm1_8[SW-1:0];
      base_eff     = (base_ff == 16'd0) ? 16'd1 : base_ff;
      obase_eff    = (obase_ff == 8'd0) ? 8'd1 : obase_ff;
      num9         = {1'b0, obase_ff} + (oen_ff ? {1'b0, ow_ff} : 9'd0);
      begin_eff    = started_ff ? {1'b0, begin_ff} : soc8;
      step_val     = step_vld_ff[socm1] ? step_rd_ff : 16'd0;
      meas_eff     = meas_vld_ff[socm1] ? meas_rd_ff : 32'hFFFF_FFFF;
      fin_step_val = step_vld_ff[fin_idx_ff] ? step_rd_ff : 16'd0;
      fin_sum      = run_ff + {8'd0, fin_step_val};
      step_ok      = soc8 < 8'(STEPS);
      meas_upd     = cmd.rpt_update && started_ff && (soc8 != 8'd0);
      bw           = $signed({1'b0, base_eff}) - $signed({1'b0, weight_ff});
   end

   // Value that is reported before the overstatement ratio.
   always_comb begin
      if (emf_ff) begin
         if (!cache_vld_ff[soc_r]) begin
            out_val = -32'sd1;
         end else if (soc8 == 8'(STEPS)) begin
            out_val = 32'sd0;
         end else begin
            out_val = cache_rd_ff;
         end
      end else begin
         out_val = $signed({8'd0, rem_rd_ff});
      end
   end

   // Multiplier operand selection.
   always_comb begin
      case (cmd.mul_sel)
         MUL_MEAS_BASE: begin
            mul_a = $signed({1'b0, meas_eff});
            mul_b = $signed({9'd0, base_eff});
         end
         MUL_W_T: begin
            mul_a = {t_ff[31], t_ff};
            mul_b = $signed({9'd0, weight_ff});
         end
         MUL_BW_MF: begin
            mul_a = {mf_ff[31], mf_ff};
            mul_b = {{8{bw[16]}}, bw};
         end
         MUL_REM_F: begin
            mul_a = {factor_ff[31], factor_ff};
            mul_b = $signed({1'b0, rem_rd_ff});
         end
         MUL_VAL_NUM: begin
            mul_a = {out_val[31], out_val};
            mul_b = $signed({16'd0, num9});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      case (cmd.div_sel)
         DIV_STEP:  divisor = step_val;
         DIV_BASE:  divisor = base_eff;
         DIV_OBASE: divisor = {8'd0, obase_eff};
         default:   divisor = 16'd1;
      endcase
   end

   ctre_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (acc_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         emf_ff    <= 1'b0;
         weight_ff <= WEIGHT_RESET;
         base_ff   <= BASE_RESET;
         oen_ff    <= 1'b0;
         ow_ff     <= 8'd0;
         obase_ff  <= OBASE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_EMF_ENABLE:       emf_ff    <= csr_wdata[0];
            CSR_SMOOTHING_WEIGHT: weight_ff <= csr_wdata;
            CSR_SMOOTHING_BASE:   base_ff   <= csr_wdata;
            CSR_OVERSTATE_ENABLE: oen_ff    <= csr_wdata[0];
            CSR_OVERSTATE_WEIGHT: ow_ff     <= csr_wdata[7:0];
            CSR_OVERSTATE_BASE:   obase_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Profile step store.
   always_ff @(posedge clock) begin
      if (cmd.write_step && step_ok) begin
         step_mem[soc8[SW-1:0]] <= in_ff.profile_seconds;
      end
      if (cmd.fin_rd) begin
         step_rd_ff <= step_mem[fin_idx_ff];
      end else if (cmd.trend_rd) begin
         step_rd_ff <= step_mem[socm1];
      end
   end

   // Measured step time store.
   always_ff @(posedge clock) begin
      if (meas_upd) begin
         meas_mem[socm1] <= in_ff.now_seconds - start_time_ff;
      end
      if (cmd.trend_rd) begin
         meas_rd_ff <= meas_mem[socm1];
      end
   end

   // Remaining profile time store (suffix sums).
   always_ff @(posedge clock) begin
      if (cmd.fin_init) begin
         rem_mem[RW'(STEPS)] <= 24'd0;
      end else if (cmd.fin_wr) begin
         rem_mem[RW'(fin_idx_ff)] <= fin_sum;
      end
      if (cmd.rem_rd) begin
         rem_rd_ff <= rem_mem[soc_r];
      end
   end

   // Cached estimate store.
   always_ff @(posedge clock) begin
      if (cmd.cache_wr) begin
         cache_mem[soc_r] <= div_q;
      end
      if (cmd.rem_rd) begin
         cache_rd_ff <= cache_mem[soc_r];
      end
   end

   // Entry valid bits; an invalid entry reads as its cleared value.
   // The full-charge entry stays valid, since its estimate is always zero.
   always_ff @(posedge clock) begin
      if (reset || cmd.do_clear) begin
         step_vld_ff  <= '0;
         meas_vld_ff  <= '0;
         cache_vld_ff <= {1'b1, {STEPS{1'b0}}};
      end else begin
         if (cmd.write_step && step_ok) begin
            step_vld_ff[soc8[SW-1:0]] <= 1'b1;
         end
         if (meas_upd) begin
            meas_vld_ff[socm1] <= 1'b1;
         end
         if (cmd.cache_wr) begin
            cache_vld_ff[soc_r] <= 1'b1;
         end
      end
   end

   // Charging session state.
   always_ff @(posedge clock) begin
      if (reset || cmd.do_clear) begin
         pvalid_ff     <= 1'b0;
         started_ff    <= 1'b0;
         cur_ok_ff     <= 1'b0;
         start_time_ff <= 32'd0;
         mf_ff         <= -32'sd1;
      end else begin
         if (cmd.fin_wr && (fin_idx_ff == SW'(0))) begin
            pvalid_ff <= 1'b1;
         end
         if (cmd.rpt_update) begin
            if (!started_ff) begin
               begin_ff   <= in_ff.soc_index;
               started_ff <= 1'b1;
            end
            cur_soc_ff    <= in_ff.soc_index;
            cur_ok_ff     <= 1'b1;
            start_time_ff <= in_ff.now_seconds;
         end
         if (cmd.cache_wr) begin
            mf_ff <= factor_ff;
         end
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         in_ff <= req_data;
      end
      if (cmd.fin_init) begin
         run_ff     <= 24'd0;
         fin_idx_ff <= SW'(STEPS - 1);
      end else if (cmd.fin_wr) begin
         run_ff     <= fin_sum;
         fin_idx_ff <= fin_idx_ff - SW'(1);
      end
      if (cmd.t_base) begin
         t_ff <= $signed({16'd0, base_eff});
      end else if (cmd.t_ld) begin
         t_ff <= div_q;
      end
      if (cmd.set_factor_base) begin
         factor_ff <= $signed({16'd0, base_eff});
      end else if (cmd.factor_ld) begin
         factor_ff <= div_q;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.acc_ld) begin
         acc_ff <= prod_ff;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + prod_ff;
      end
   end

   // Result beat register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_ok || cmd.rsp_bad;
      end
      if (cmd.rsp_bad) begin
         rsp_ff.remaining_seconds <= -32'sd1;
         rsp_ff.invalid           <= 1'b1;
      end else if (cmd.rsp_ok) begin
         rsp_ff.remaining_seconds <= div_q;
         rsp_ff.invalid           <= 1'b0;
      end
   end

   always_comb begin
      status.action     = action_type'(in_ff.action);
      status.bad_rpt    = !pvalid_ff || (soc8 > 8'(STEPS));
      status.same_soc   = cur_ok_ff && (cur_soc_ff == in_ff.soc_index);
      status.cached_hit = cache_vld_ff[soc_r];
      status.need_trend = soc8 > (begin_eff + 8'd1);
      status.step_zero  = step_val == 16'd0;
      status.fin_last   = fin_idx_ff == SW'(0);
      status.div_done   = div_done;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_one_beat : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff) else $error("result beat repeated");
   a_last_cached : assert property (@(posedge clock) disable iff (reset)
      cache_vld_ff[STEPS]) else $error("full-charge entry lost its valid bit");
   a_valid_after_finish : assert property (@(posedge clock) disable iff (reset)
      (cmd.fin_wr && fin_idx_ff == SW'(0)) |=> pvalid_ff)
      else $error("profile not marked valid after finish");

endmodule

// ----- src/ctre_ctrl.sv -----
// Controller state machine of the estimator: sequences the datapath.
// Depends on ctre_pkg for states, commands and status.
module ctre_ctrl import ctre_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.action)
               ACT_FINISH: state_in = ST_FIN_INIT;
               ACT_REPORT: state_in = ST_RPT_CHECK;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_FIN_INIT: state_in = ST_FIN_RD;
         ST_FIN_RD:   state_in = ST_FIN_WR;
         ST_FIN_WR:   state_in = status.fin_last ? ST_IDLE : ST_FIN_RD;
         ST_RPT_CHECK: begin
            if (status.bad_rpt) begin
               state_in = ST_IDLE;
            end else if (status.same_soc || status.cached_hit) begin
               state_in = ST_OUT_RD;
            end else if (status.need_trend) begin
               state_in = ST_TR_RD;
            end else begin
               state_in = ST_CA_RD;
            end
         end
         ST_TR_RD:  state_in = ST_TR_MUL;
         ST_TR_MUL: state_in = status.step_zero ? ST_FC_MUL1 : ST_TR_ACC;
         ST_TR_ACC: state_in = ST_TR_DST;
         ST_TR_DST: state_in = ST_TR_DWT;
         ST_TR_DWT: begin
            if (status.div_done) begin
               state_in = ST_FC_MUL1;
            end
         end
         ST_FC_MUL1: state_in = ST_FC_MUL2;
         ST_FC_MUL2: state_in = ST_FC_ADD;
         ST_FC_ADD:  state_in = ST_FC_DST;
         ST_FC_DST:  state_in = ST_FC_DWT;
         ST_FC_DWT: begin
            if (status.div_done) begin
               state_in = ST_CA_RD;
            end
         end
         ST_CA_RD:  state_in = ST_CA_MUL;
         ST_CA_MUL: state_in = ST_CA_ACC;
         ST_CA_ACC: state_in = ST_CA_DST;
         ST_CA_DST: state_in = ST_CA_DWT;
         ST_CA_DWT: begin
            if (status.div_done) begin
               state_in = ST_OUT_RD;
            end
         end
         ST_OUT_RD:  state_in = ST_OUT_MUL;
         ST_OUT_MUL: state_in = ST_OUT_ACC;
         ST_OUT_ACC: state_in = ST_OUT_DST;
         ST_OUT_DST: state_in = ST_OUT_DWT;
         ST_OUT_DWT: begin
            if (status.div_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd         = '0;
      cmd.mul_sel = MUL_MEAS_BASE;
      cmd.div_sel = DIV_BASE;
      case (state_ff)
         ST_IDLE: cmd.load_in = start;
         ST_DECODE: begin
            cmd.do_clear   = status.action == ACT_CLEAR;
            cmd.write_step = status.action == ACT_LOAD;
         end
         ST_FIN_INIT: cmd.fin_init = 1'b1;
         ST_FIN_RD:   cmd.fin_rd   = 1'b1;
         ST_FIN_WR:   cmd.fin_wr   = 1'b1;
         ST_RPT_CHECK: begin
            cmd.rsp_bad    = status.bad_rpt;
            cmd.rpt_update = !status.bad_rpt && !status.same_soc;
            cmd.set_factor_base = !status.bad_rpt && !status.same_soc &&
                                  !status.cached_hit && !status.need_trend;
         end
         ST_TR_RD: cmd.trend_rd = 1'b1;
         ST_TR_MUL: begin
            cmd.t_base  = status.step_zero;
            cmd.mul_en  = !status.step_zero;
            cmd.mul_sel = MUL_MEAS_BASE;
         end
         ST_TR_ACC: cmd.acc_ld = 1'b1;
         ST_TR_DST: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_STEP;
         end
         ST_TR_DWT: cmd.t_ld = status.div_done;
         ST_FC_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_W_T;
         end
         ST_FC_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_BW_MF;
            cmd.acc_ld  = 1'b1;
         end
         ST_FC_ADD: cmd.acc_add = 1'b1;
         ST_FC_DST: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_BASE;
         end
         ST_FC_DWT: cmd.factor_ld = status.div_done;
         ST_CA_RD:  cmd.rem_rd = 1'b1;
         ST_CA_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_REM_F;
         end
         ST_CA_ACC: cmd.acc_ld = 1'b1;
         ST_CA_DST: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_BASE;
         end
         ST_CA_DWT: cmd.cache_wr = status.div_done;
         ST_OUT_RD: cmd.rem_rd = 1'b1;
         ST_OUT_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_VAL_NUM;
         end
         ST_OUT_ACC: cmd.acc_ld = 1'b1;
         ST_OUT_DST: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_OBASE;
         end
         ST_OUT_DWT: cmd.rsp_ok = status.div_done;
         default: ;
      endcase
   end

   assign busy = state_ff != ST_IDLE;

   a_accept_decodes : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start) |=> state_ff == ST_DECODE)
      else $error("accepted item not decoded");
   a_result_ends : assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_ok || cmd.rsp_bad) |=> state_ff == ST_IDLE)
      else $error("controller busy after result");
   a_div_wait : assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == ST_TR_DWT || state_ff == ST_FC_DWT ||
                           state_ff == ST_CA_DWT || state_ff == ST_OUT_DWT))
      else $error("division finished outside a wait state");

endmodule

// ----- src/charge_time_remaining_estimator_core.sv -----
// A clear or profile write is done in the decode state. A finish walks the profile
// from the last entry down, a read and a write per entry, through the step store's
// single read port. An invalid report ends in its check state; an already visited
// percent goes to the ratio alone, else up to trend, factor, estimate and ratio
// use the shared one-bit-a-cycle divider. One item at a time: busy blocks start.
// Synchronous reset gives the cleared profile state and the register reset values.
module charge_time_remaining_estimator_core import ctre_pkg::*; #(
   parameter int SOC_STEPS = SOC_STEPS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   ctre_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   ctre_dp #(
      .STEPS (SOC_STEPS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule
